// ----- rtl/lbcd_pkg.sv -----
// ----------------------------------------------------------------------------
// lbcd_pkg
// types and constants shared by the block cache directory
// ----------------------------------------------------------------------------
`default_nettype none

package lbcd_pkg;

    typedef enum logic [1:0] {
        CMD_ACCESS = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FILL      = 3'd1,
        ST_PAST_END  = 3'd2,
        ST_FILL_FAIL = 3'd3,
        ST_PROTOCOL  = 3'd4
    } t_status;

    localparam logic [0:0] REG_BLOCK_SIZE_LOG2 = 1'd0;
    localparam logic [0:0] REG_BLOCKS_IN_USE   = 1'd1;

    localparam int MAX_SHIFT = 16;

endpackage

`default_nettype wire

// ----- rtl/lru_block_cache_directory.sv -----
// ----------------------------------------------------------------------------
// lru_block_cache_directory
// tag search, lru victim choice and fill bookkeeping of a block cache
// ----------------------------------------------------------------------------
// Each command word is handled alone. An access walks the slots one per cycle
// through a single tag comparator; on a miss a second walk looks for the first
// invalid slot while tracking the lowest age through one shared compare. The slot
// walk through the shared comparator sets how long an access takes, which grows
// with the number of slots in use. The result register frees the input side once
// the word has been taken.
`default_nettype none

module lru_block_cache_directory #(
    parameter int MAX_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_byte_offset,
    input  wire logic [15:0] i_request_len,
    input  wire logic        i_fill_ok,
    input  wire logic [16:0] i_fill_len,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [3:0]       o_slot,
    output logic [31:0]      o_fill_address,
    output logic [15:0]      o_in_block,
    output logic [15:0]      o_chunk_len,
    output logic [31:0]      o_hit_count,
    output logic [31:0]      o_miss_count,
    output logic [31:0]      o_fill_byte_count
);
    import lbcd_pkg::*;

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_VICTIM, S_SERVE, S_OUT
    } t_state;

    t_state r_state;
    logic [4:0] r_bsl, r_biu;
    logic [31:0] r_tag [MAX_SLOTS];
    logic [16:0] r_len [MAX_SLOTS];
    logic [31:0] r_age [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_vld;
    logic [31:0] r_clock, r_hits, r_miss, r_fbytes;
    logic r_pend;
    logic [SW-1:0] r_pslot;
    logic [31:0] r_pblock;
    logic [15:0] r_pinb, r_preq;

    logic [31:0] r_blk;
    logic [15:0] r_inb, r_req;
    logic [SW-1:0] r_idx, r_best;
    logic [31:0] r_bage;
    logic [CW-1:0] r_n;
    logic [16:0] r_slen;

    logic [4:0] sh;
    logic [CW-1:0] n_slots;
    logic [16:0] bsize;
    logic last;
    logic [SW-1:0] victim;

    always_comb begin
        sh = (r_bsl > 5'(MAX_SHIFT)) ? 5'(MAX_SHIFT) : r_bsl;
        bsize = 17'd1 << sh;
        if (r_biu == 5'd0) n_slots = CW'(1);
        else if (32'(r_biu) > 32'(MAX_SLOTS)) n_slots = CW'(MAX_SLOTS);
        else n_slots = CW'(r_biu);
        last = (CW'(r_idx) + CW'(1)) >= r_n;
        if (!r_vld[r_idx]) victim = r_idx;
        else if (r_idx == '0 || r_age[r_idx] < r_bage) victim = r_idx;
        else victim = r_best;
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bsl <= 5'd9;
            r_biu <= 5'd16;
            r_vld <= '0;
            r_clock <= '0;
            r_hits <= '0;
            r_miss <= '0;
            r_fbytes <= '0;
            r_pend <= 1'b0;
            r_pslot <= '0;
            r_pblock <= '0;
            r_pinb <= '0;
            r_preq <= '0;
            o_valid <= 1'b0;
            for (int k = 0; k < MAX_SLOTS; k++) begin
                r_len[k] <= '0;
                r_age[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_BLOCK_SIZE_LOG2) r_bsl <= i_cfg_data;
                else r_biu <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        o_fill_address <= '0;
                        o_chunk_len <= '0;
                        r_n <= n_slots;
                        r_idx <= '0;
                        r_blk <= i_byte_offset >> sh;
                        if (i_cmd == CMD_ACCESS && !r_pend && i_request_len != 16'd0) begin
                            r_inb <= 16'(i_byte_offset & ((32'd1 << sh) - 32'd1));
                            r_req <= i_request_len;
                            r_state <= S_SEARCH;
                        end else if (i_cmd == CMD_FILL && r_pend) begin
                            r_pend <= 1'b0;
                            o_slot <= 4'(r_pslot);
                            o_in_block <= r_pinb;
                            r_inb <= r_pinb;
                            r_req <= r_preq;
                            if (i_fill_ok) begin
                                r_slen <= (i_fill_len > bsize) ? bsize : i_fill_len;
                                r_len[r_pslot] <= (i_fill_len > bsize) ? bsize : i_fill_len;
                                r_tag[r_pslot] <= r_pblock;
                                r_vld[r_pslot] <= 1'b1;
                                r_miss <= r_miss + 32'd1;
                                r_fbytes <= r_fbytes
                                    + 32'((i_fill_len > bsize) ? bsize : i_fill_len);
                                r_clock <= r_clock + 32'd1;
                                r_age[r_pslot] <= r_clock + 32'd1;
                                r_state <= S_SERVE;
                            end else begin
                                o_status <= ST_FILL_FAIL;
                                r_state <= S_OUT;
                            end
                        end else if (i_cmd == CMD_FLUSH) begin
                            r_vld <= '0;
                            r_pend <= 1'b0;
                            for (int k = 0; k < MAX_SLOTS; k++) begin
                                r_len[k] <= '0;
                                r_age[k] <= '0;
                            end
                            o_status <= ST_OK;
                            o_slot <= '0;
                            o_in_block <= '0;
                            r_state <= S_OUT;
                        end else begin
                            o_status <= ST_PROTOCOL;
                            o_slot <= '0;
                            o_in_block <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SEARCH: begin
                    o_in_block <= r_inb;
                    if (r_vld[r_idx] && r_tag[r_idx] == r_blk) begin
                        r_hits <= r_hits + 32'd1;
                        r_clock <= r_clock + 32'd1;
                        r_age[r_idx] <= r_clock + 32'd1;
                        r_slen <= r_len[r_idx];
                        o_slot <= 4'(r_idx);
                        r_state <= S_SERVE;
                    end else if (last) begin
                        r_idx <= '0;
                        r_best <= '0;
                        r_bage <= '1;
                        r_state <= S_VICTIM;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_VICTIM: begin
                    if (!r_vld[r_idx] || last) begin
                        r_vld[victim] <= 1'b0;
                        r_len[victim] <= '0;
                        r_pend <= 1'b1;
                        r_pslot <= victim;
                        r_pblock <= r_blk;
                        r_pinb <= r_inb;
                        r_preq <= r_req;
                        o_status <= ST_FILL;
                        o_slot <= 4'(victim);
                        o_fill_address <= r_blk << sh;
                        r_state <= S_OUT;
                    end else begin
                        if (r_idx == '0 || r_age[r_idx] < r_bage) begin
                            r_bage <= r_age[r_idx];
                            r_best <= r_idx;
                        end
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_SERVE: begin
                    if (17'(r_inb) >= r_slen) begin
                        o_status <= ST_PAST_END;
                    end else begin
                        o_status <= ST_OK;
                        o_chunk_len <= ((r_slen - 17'(r_inb)) > 17'(r_req))
                            ? r_req : 16'(r_slen - 17'(r_inb));
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_hit_count <= r_hits;
                        o_miss_count <= r_miss;
                        o_fill_byte_count <= r_fbytes;
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result held");
    a_fill_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FILL) |-> r_pend) else $error("fill not pending");
    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clock != $past(r_clock)) |-> (r_clock == $past(r_clock) + 32'd1))
        else $error("clock jumped");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the block cache directory against its own predictor
// ----------------------------------------------------------------------------
// Command words go in through a valid/ready sender with random gaps. Every
// accepted word is run through a local model of the tag search, the lru
// victim choice and the fill bookkeeping. The expected result is queued and
// compared field by field with each result word taken from the block. The
// receiver also stalls at random. The run covers several block sizes and
// slot counts, including both extremes and the clamped values.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbcd_pkg::*;

    localparam int NSLOTS = 16;
    localparam int LIMIT  = 2000000;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] fill_address;
        logic [15:0] in_block;
        logic [15:0] chunk_len;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] fill_byte_count;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [31:0] i_byte_offset;
    logic [15:0] i_request_len;
    logic        i_fill_ok;
    logic [16:0] i_fill_len;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [3:0]  o_slot;
    logic [31:0] o_fill_address;
    logic [15:0] o_in_block;
    logic [15:0] o_chunk_len;
    logic [31:0] o_hit_count;
    logic [31:0] o_miss_count;
    logic [31:0] o_fill_byte_count;

    lru_block_cache_directory dut (.*);

    // predictor state
    logic [4:0]  cfg_shift;
    logic [4:0]  cfg_slots;
    logic [31:0] tag_mem   [NSLOTS];
    logic        valid_mem [NSLOTS];
    logic [16:0] len_mem   [NSLOTS];
    logic [31:0] age_mem   [NSLOTS];
    logic [31:0] use_clock;
    logic [31:0] hits, misses, filled;
    logic        pending;
    logic [3:0]  pend_slot;
    logic [31:0] pend_block;
    logic [15:0] pend_inb;
    logic [15:0] pend_req;

    t_result expected_q [$];
    int      mismatches = 0;
    int      cycles = 0;
    int      stall_hold = 0;
    bit      rx_long_stall;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("lru_block_cache_directory test failed");
            $finish;
        end
    end

    function automatic void model_reset();
        cfg_shift = 5'd9;
        cfg_slots = 5'd16;
        for (int i = 0; i < NSLOTS; i++) begin
            valid_mem[i] = 1'b0;
            len_mem[i]   = '0;
            age_mem[i]   = '0;
            tag_mem[i]   = '0;
        end
        use_clock = '0;
        hits = '0;
        misses = '0;
        filled = '0;
        pending = 1'b0;
        pend_slot = '0;
        pend_block = '0;
        pend_inb = '0;
        pend_req = '0;
    endfunction

    function automatic void judge_slot(int s, logic [15:0] inb, logic [15:0] req,
                                       ref t_result r);
        logic [16:0] chunk;
        if ({1'b0, inb} >= len_mem[s]) begin
            r.status = ST_PAST_END;
        end else begin
            chunk = len_mem[s] - {1'b0, inb};
            if (chunk > {1'b0, req}) chunk = {1'b0, req};
            r.status    = ST_OK;
            r.chunk_len = chunk[15:0];
        end
    endfunction

    function automatic t_result predict_directory(logic [1:0] cmd, logic [31:0] off,
                                                  logic [15:0] req, logic ok,
                                                  logic [16:0] flen);
        t_result r;
        int      sh, n, s;
        bit      hit, found;
        logic [16:0] bsize, ln;
        logic [31:0] blk, best;
        r = '0;
        r.status = ST_PROTOCOL;
        sh = (cfg_shift > 16) ? 16 : cfg_shift;
        n = (cfg_slots == 0) ? 1 : ((cfg_slots > NSLOTS) ? NSLOTS : cfg_slots);
        bsize = 17'd1 << sh;
        if (cmd == CMD_ACCESS && !pending && req != 0) begin
            blk = off >> sh;
            r.in_block = 16'(off & (32'(bsize) - 1));
            hit = 0;
            s = 0;
            for (int i = 0; i < n; i++) begin
                if (!hit && valid_mem[i] && tag_mem[i] == blk) begin
                    hit = 1;
                    s = i;
                end
            end
            if (hit) begin
                hits = hits + 32'd1;
                use_clock = use_clock + 32'd1;
                age_mem[s] = use_clock;
                r.slot = 4'(s);
                judge_slot(s, r.in_block, req, r);
            end else begin
                found = 0;
                for (int i = 0; i < n; i++) begin
                    if (!found && !valid_mem[i]) begin
                        s = i;
                        found = 1;
                    end
                end
                if (!found) begin
                    s = 0;
                    best = age_mem[0];
                    for (int i = 1; i < n; i++) begin
                        if (age_mem[i] < best) begin
                            best = age_mem[i];
                            s = i;
                        end
                    end
                end
                valid_mem[s] = 1'b0;
                len_mem[s] = '0;
                pending = 1'b1;
                pend_slot = 4'(s);
                pend_block = blk;
                pend_inb = r.in_block;
                pend_req = req;
                r.status = ST_FILL;
                r.slot = 4'(s);
                r.fill_address = blk << sh;
            end
        end else if (cmd == CMD_FILL && pending) begin
            s = pend_slot;
            pending = 1'b0;
            r.slot = pend_slot;
            r.in_block = pend_inb;
            if (ok) begin
                ln = (flen > bsize) ? bsize : flen;
                tag_mem[s] = pend_block;
                valid_mem[s] = 1'b1;
                len_mem[s] = ln;
                misses = misses + 32'd1;
                filled = filled + 32'(ln);
                use_clock = use_clock + 32'd1;
                age_mem[s] = use_clock;
                judge_slot(s, pend_inb, pend_req, r);
            end else begin
                valid_mem[s] = 1'b0;
                len_mem[s] = '0;
                r.status = ST_FILL_FAIL;
            end
        end else if (cmd == CMD_FLUSH) begin
            for (int i = 0; i < NSLOTS; i++) begin
                valid_mem[i] = 1'b0;
                len_mem[i] = '0;
                age_mem[i] = '0;
            end
            pending = 1'b0;
            r.status = ST_OK;
        end
        r.hit_count = hits;
        r.miss_count = misses;
        r.fill_byte_count = filled;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_status, o_slot, o_fill_address, o_in_block, o_chunk_len,
                       o_hit_count, o_miss_count, o_fill_byte_count};
                if (expected_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (rx_long_stall) begin
                i_ready <= 1'b0;
            end else if (stall_hold > 0) begin
                stall_hold <= stall_hold - 1;
                i_ready <= 1'b0;
            end else if (!i_ready && $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
            end else if (i_ready && $urandom_range(0, 2) == 0) begin
                stall_hold <= gap_len();
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [31:0] off, logic [15:0] req,
                             logic ok, logic [16:0] flen, bit no_gap = 0);
        int g;
        t_result r;
        g = no_gap ? 0 : gap_len();
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_byte_offset <= off;
        i_request_len <= req;
        i_fill_ok     <= ok;
        i_fill_len    <= flen;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = predict_directory(cmd, off, req, ok, flen);
        expected_q.push_back(r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [4:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_BLOCK_SIZE_LOG2) cfg_shift = val;
        else cfg_slots = val;
    endtask

    // access, fill on miss; fills succeed mostly
    task automatic do_access(logic [31:0] off, logic [15:0] req);
        send_word(CMD_ACCESS, off, req, 1'($urandom_range(0, 1)), 17'($urandom));
        if (pending)
            send_word(CMD_FILL, $urandom, 16'($urandom), ($urandom_range(0, 9) != 0),
                      ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 17'h1ffff))
                                                  : 17'($urandom_range(0, 600)));
    endtask

    task automatic test_directed();
        send_word(CMD_FILL, 32'h0, 16'd1, 1'b1, 17'd10);
        send_word(CMD_ACCESS, 32'h0, 16'd0, 1'b0, 17'd0);
        send_word(CMD_RSVD, 32'hffffffff, 16'hffff, 1'b1, 17'h1ffff);
        send_word(CMD_ACCESS, 32'hffffffff, 16'hffff, 1'b0, 17'd0);
        send_word(CMD_ACCESS, 32'h100, 16'd1, 1'b0, 17'd0);
        send_word(CMD_FILL, 32'h0, 16'd1, 1'b1, 17'h1ffff);
        send_word(CMD_ACCESS, 32'h1000, 16'd5, 1'b0, 17'd0);
        send_word(CMD_FILL, 32'h0, 16'd1, 1'b1, 17'd100);
        send_word(CMD_ACCESS, 32'h1080, 16'hffff, 1'b0, 17'd0);
        send_word(CMD_ACCESS, 32'h1010, 16'd3, 1'b0, 17'd0);
        send_word(CMD_ACCESS, 32'h2000, 16'd5, 1'b0, 17'd0);
        send_word(CMD_FILL, 32'h0, 16'd1, 1'b0, 17'd100);
        send_word(CMD_ACCESS, 32'h0, 16'd8, 1'b0, 17'd0);
        send_word(CMD_FILL, 32'h0, 16'd1, 1'b1, 17'd0);
        send_word(CMD_FLUSH, 32'h0, 16'd1, 1'b0, 17'd0);
        send_word(CMD_ACCESS, 32'h1000, 16'd5, 1'b0, 17'd0);
        send_word(CMD_FLUSH, 32'h0, 16'd1, 1'b0, 17'd0);
        send_word(CMD_FILL, 32'h0, 16'd1, 1'b1, 17'd1);
    endtask

    task automatic test_settings(logic [4:0] sh, logic [4:0] ns, int count);
        logic [31:0] base, off;
        int          span;
        write_reg(REG_BLOCK_SIZE_LOG2, sh);
        write_reg(REG_BLOCKS_IN_USE, ns);
        base = $urandom;
        span = ((ns == 0) ? 1 : ((ns > 16) ? 16 : ns)) + 3;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0: send_word(CMD_FLUSH, $urandom, 16'($urandom), 1'($urandom),
                             17'($urandom));
                1: send_word(2'($urandom), $urandom, 16'($urandom_range(0, 1)),
                             1'($urandom), 17'($urandom));
                2: do_access($urandom, 16'($urandom));
                default: begin
                    off = base + ($urandom_range(0, span - 1) << ((sh > 16) ? 16 : sh))
                          + $urandom_range(0, 700);
                    do_access(off, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(1, 300)));
                end
            endcase
        end
    endtask

    task automatic test_output_stall();
        drain();
        rx_long_stall <= 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                rx_long_stall <= 1'b0;
            end
            for (int k = 0; k < 12; k++)
                send_word(CMD_ACCESS, 32'(k << 9), 16'd4, 1'b0, 17'd0, 1);
        join
        drain();
    endtask

    task automatic test_counter_wrap();
        // repeated full 64k fills at the widest block size
        write_reg(REG_BLOCK_SIZE_LOG2, 5'd16);
        write_reg(REG_BLOCKS_IN_USE, 5'd1);
        for (int k = 0; k < 40; k++) begin
            send_word(CMD_ACCESS, 32'(k) << 16, 16'hffff, 1'b0, 17'd0, 1);
            send_word(CMD_FILL, 32'h0, 16'd1, 1'b1, 17'h10000, 1);
        end
    endtask

    initial begin
        rx_long_stall = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_cmd = '0;
        i_byte_offset = '0;
        i_request_len = '0;
        i_fill_ok = 1'b0;
        i_fill_len = '0;
        model_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_output_stall();
        test_settings(5'd9, 5'd16, 250);
        test_settings(5'd0, 5'd1, 150);
        test_settings(5'd4, 5'd3, 250);
        test_settings(5'd31, 5'd0, 100);
        test_settings(5'd16, 5'd31, 150);
        test_settings(5'd17, 5'd16, 100);
        test_settings(5'd6, 5'd5, 300);
        test_settings(5'd2, 5'd16, 250);
        test_counter_wrap();
        test_settings(5'd8, 5'd8, 150);
        drain();

        if (mismatches == 0 && expected_q.size() == 0)
            $display("lru_block_cache_directory test passed");
        else
            $display("lru_block_cache_directory test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/lbcd_pkg.sv
rtl/lru_block_cache_directory.sv
test/testbench.sv
